/* design/pulse_beat_detector_bpm_core_assert.svh */
// ----------------------------------------------------------------------------
// pulse beat detector assertion macros
// shared property templates for the beat detector core
// ----------------------------------------------------------------------------
`ifndef PULSE_BEAT_DETECTOR_BPM_CORE_ASSERT_SVH
`define PULSE_BEAT_DETECTOR_BPM_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PBD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbd check failed");

// next-cycle implication, checked outside reset
`define PBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbd check failed");

`endif

/* design/pbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_pkg
// widths, constants and shared types of the pulse beat detector
// ----------------------------------------------------------------------------
package pbd_pkg;

   localparam int WINDOW   = 10;
   localparam int SAMPLE_W = 10;
   localparam int TIME_W   = 32;
   localparam int THR_W    = 11;
   localparam int BPM_W    = 8;
   localparam int TOTAL_W  = 16;
   localparam int AVG_W    = 10;
   localparam int SUM_W    = $clog2(WINDOW * 1023 + 1);
   localparam int POS_W    = $clog2(WINDOW);
   localparam int DIV_W    = 16;
   localparam int DVS_W    = 11;
   localparam int DCNT_W   = $clog2(DIV_W);
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 40;

   // sum / WINDOW as a multiply by a rounded-up reciprocal and a shift,
   // exact for every sum that fits in SUM_W bits
   localparam int AVG_SHIFT  = SUM_W + POS_W;
   localparam int AVG_MUL    = (2 ** AVG_SHIFT + WINDOW - 1) / WINDOW;
   localparam int AVG_MUL_W  = SUM_W + 1;
   localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;

   localparam logic [TIME_W-1:0]  REFRACT_MS = TIME_W'(300);
   localparam logic [TIME_W-1:0]  MAX_GAP_MS = TIME_W'(2000);
   localparam logic [DIV_W-1:0]   BPM_NUM    = DIV_W'(60000);
   localparam logic [THR_W-1:0]   BEAT_MARGIN   = THR_W'(20);
   localparam logic [THR_W-1:0]   STRONG_MARGIN = THR_W'(50);
   localparam logic [BPM_W-1:0]   BPM_LOW    = BPM_W'(40);
   localparam logic [BPM_W-1:0]   BPM_HIGH   = BPM_W'(180);
   localparam logic [THR_W-1:0]   THR_RESET  = THR_W'(512);

   // register index, taken from paddr bit 2
   localparam logic REG_THRESHOLD  = 1'b0;
   localparam logic REG_CALIBRATED = 1'b1;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

endpackage

/* design/pbd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pbd_div (
   input  logic                      clock,
   input  logic                      reset,
   input  pbd_pkg::div_req_type      div_req,
   output logic                      div_done,
   output logic [pbd_pkg::DIV_W-1:0] div_quot
);
   import pbd_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [DIV_W-1:0]  quo_ff;

   logic [DVS_W:0]    rem_sh;
   logic [DVS_W:0]    diff;
   logic [DVS_W-1:0]  rem_in;
   logic              qbit;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      qbit   = ~diff[DVS_W];
      rem_in = qbit ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(DIV_W - 1);
            rem_ff  <= '0;
            dvs_ff  <= div_req.divisor;
            quo_ff  <= div_req.dividend;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DIV_W-2:0], qbit};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_done = done_ff;
   assign div_quot = quo_ff;

endmodule

/* design/pulse_beat_detector_bpm_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_beat_detector_bpm_core
// moving-average threshold heartbeat detector with beats-per-minute estimate
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one sensor sample and its millisecond timestamp per
//   request; rsp channel returns exactly one result per request, in order.
//   csr port holds the beat threshold (0x0) and the calibrated bit (0x4);
//   write them only while no request is in flight.
// sequencing:
//   one request at a time. the moving average comes from a reciprocal
//   multiply, and the beat decision follows the accept in a separate
//   decide state. when a new rate is computed the 16-bit serial divider
//   then runs for 60000/interval before the result is loaded into the
//   output register; the next request is taken once it has been loaded.
// reset:
//   clears the sample ring, running sum, peak and beat history, rate and
//   count at once; threshold returns to 512, calibrated to 0.
// stall:
//   a finished result waits in the output register; a new request is taken
//   meanwhile, and its result waits until the held one has left.
// ----------------------------------------------------------------------------
module pulse_beat_detector_bpm_core (
   input  logic                       clock,
   input  logic                       reset,
   // sample [9:0], time_ms [41:10], zero fill [47:42]
   input  logic [pbd_pkg::REQ_W-1:0]  req_tdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // beat [0], rate_bpm [8:1], beats_counted [24:9], moving_average [34:25],
   // reading_valid [35], strong_peak [36], zero fill [39:37]
   output logic [pbd_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import pbd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_BPM_RUN,
      S_BPM_WAIT,
      S_OUT
   } state_type;

   state_type          state_ff;

   logic [THR_W-1:0]   thr_ff;
   logic               calib_ff;

   logic [SAMPLE_W-1:0] ring_ff [WINDOW];
   logic [POS_W-1:0]   pos_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic               peak_latched_ff;
   logic [TIME_W-1:0]  last_peak_ff;
   logic [TIME_W-1:0]  last_beat_ff;
   logic               beat_seen_ff;
   logic [BPM_W-1:0]   bpm_ff;
   logic [TOTAL_W-1:0] total_ff;

   logic [SAMPLE_W-1:0] sample_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [AVG_W-1:0]   avg_ff;
   logic               beat_ff;
   logic               strong_ff;
   logic [DVS_W-1:0]   gap_ff;

   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   logic [SAMPLE_W-1:0] req_sample;
   logic [TIME_W-1:0]  req_time;
   logic               req_fire;
   logic [SUM_W-1:0]   sum_in;
   logic [POS_W-1:0]   pos_in;

   div_req_type        div_req;
   logic               div_done;
   logic [DIV_W-1:0]   div_quot;

   logic [AVG_PROD_W-1:0] avg_prod;
   logic [AVG_W-1:0]   avg_now;
   logic [THR_W-1:0]   s_ext;
   logic               above;
   logic [TIME_W-1:0]  peak_gap;
   logic [TIME_W-1:0]  beat_gap;
   logic               beat_now;
   logic               rearm;
   logic               bpm_go;
   logic               strong_now;
   logic               valid_now;
   logic               out_load;
   logic               csr_wr;

   assign req_sample = req_tdata[SAMPLE_W-1:0];
   assign req_time   = req_tdata[SAMPLE_W +: TIME_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign sum_in = sum_ff - SUM_W'(ring_ff[pos_ff]) + SUM_W'(req_sample);
   assign pos_in = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;

   always_comb begin
      div_req.start    = (state_ff == S_BPM_RUN);
      div_req.dividend = BPM_NUM;
      div_req.divisor  = gap_ff;
   end

   pbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   // beat decision, evaluated once the running sum holds the new sample
   always_comb begin
      avg_prod   = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_MUL);
      avg_now    = avg_prod[AVG_SHIFT +: AVG_W];
      s_ext      = THR_W'(sample_ff);
      above      = (s_ext > thr_ff) && (s_ext > THR_W'(avg_now) + BEAT_MARGIN);
      peak_gap   = time_ff - last_peak_ff;
      beat_gap   = time_ff - last_beat_ff;
      beat_now   = above && !peak_latched_ff && (peak_gap > REFRACT_MS);
      rearm      = !above && (sample_ff < avg_now);
      bpm_go     = beat_now && beat_seen_ff && calib_ff &&
                   (beat_gap > REFRACT_MS) && (beat_gap < MAX_GAP_MS);
      strong_now = (s_ext > thr_ff) && (s_ext > THR_W'(avg_now) + STRONG_MARGIN);
      valid_now  = (bpm_ff >= BPM_LOW) && (bpm_ff <= BPM_HIGH) && calib_ff;
      out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         pos_ff          <= '0;
         sum_ff          <= '0;
         peak_latched_ff <= 1'b0;
         last_peak_ff    <= '0;
         last_beat_ff    <= '0;
         beat_seen_ff    <= 1'b0;
         bpm_ff          <= '0;
         total_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  ring_ff[pos_ff] <= req_sample;
                  sum_ff          <= sum_in;
                  pos_ff          <= pos_in;
                  sample_ff       <= req_sample;
                  time_ff         <= req_time;
                  state_ff        <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               avg_ff    <= avg_now;
               beat_ff   <= beat_now;
               strong_ff <= strong_now;
               gap_ff    <= beat_gap[DVS_W-1:0];
               if (beat_now) begin
                  peak_latched_ff <= 1'b1;
                  last_peak_ff    <= time_ff;
                  last_beat_ff    <= time_ff;
                  beat_seen_ff    <= 1'b1;
               end else if (rearm) begin
                  peak_latched_ff <= 1'b0;
               end
               state_ff <= bpm_go ? S_BPM_RUN : S_OUT;
            end
            S_BPM_RUN: begin
               state_ff <= S_BPM_WAIT;
            end
            S_BPM_WAIT: begin
               if (div_done) begin
                  bpm_ff   <= div_quot[BPM_W-1:0];
                  total_ff <= total_ff + 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {3'b000, strong_ff, valid_now, avg_ff,
                                   total_ff, bpm_ff, beat_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THR_RESET;
         calib_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_THRESHOLD:  thr_ff   <= csr_pwdata[THR_W-1:0];
            REG_CALIBRATED: calib_ff <= csr_pwdata[0];
            default: begin
               thr_ff <= thr_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_THRESHOLD:  csr_prdata = {{(32 - THR_W){1'b0}}, thr_ff};
         REG_CALIBRATED: csr_prdata = {31'd0, calib_ff};
         default:        csr_prdata = '0;
      endcase
   end

   `include "pulse_beat_detector_bpm_core_assert.svh"

   `PBD_ASSERT_NEXT(a_req_starts_work, clock, reset, req_fire, state_ff == S_DECIDE)
   `PBD_ASSERT_NOW(a_done_when_waiting, clock, reset, div_done, state_ff == S_BPM_WAIT)
   `PBD_ASSERT_NOW(a_count_from_divider, clock, reset, !$stable(total_ff),
                   $past(state_ff) == S_BPM_WAIT)
   `PBD_ASSERT_NOW(a_pos_in_window, clock, reset, 1'b1, pos_ff <= POS_W'(WINDOW - 1))

endmodule
